[hw/rtl/hrs_pkg.sv]
// Shared types and constants for the heart rate smoother.
package hrs_pkg;

    localparam int RATE_W        = 8;
    localparam int PHASE_W       = 2;
    localparam int CFG_INDEX_W   = 8;
    localparam int S_DATA_W      = 8;
    localparam int M_DATA_W      = 16;

    localparam int RAW_DEPTH_DEF    = 8;
    localparam int STABLE_COUNT_DEF = 4;
    localparam int SMOOTH_DEPTH_DEF = 8;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_ACQUIRE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TRACK   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DRAIN   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_BAND      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTLIER_BAND   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RATE       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_RUN_LIMIT = 8'd3;

    // register reset values
    localparam logic [RATE_W-1:0] NEAR_BAND_RST      = 8'd5;
    localparam logic [RATE_W-1:0] OUTLIER_BAND_RST   = 8'd15;
    localparam logic [RATE_W-1:0] MIN_RATE_RST       = 8'd40;
    localparam logic [RATE_W-1:0] ZERO_RUN_LIMIT_RST = 8'd3;

    // per-cycle control of one history chain
    typedef struct packed {
        logic clear;   // zero every cell
        logic shift;   // newest value enters cell 0, others move up
        logic rotate;  // every cell takes its upper neighbor, cell 0 wraps to the top
    } cell_ctl_t;

endpackage

[hw/rtl/heart_rate_smoother.sv]
// Heart rate smoother top level: phase control, sweeps, divider and stream ports.
//
//  channel   | ports                                | payload
//  ----------+--------------------------------------+----------------------------------
//  input     | s_tvalid s_tready s_tdata[7:0]       | raw_rate
//  result    | m_tvalid m_tready m_tdata[15:0]      | smooth_rate [7:0], phase [9:8]
//  config    | cfg_valid cfg_ready cfg_index cfg_data | register index, 8-bit value
//
// Steps per request: acquire sweeps the raw history and goes to the final state;
// track sweeps the smoothing buffer, then runs the one-bit-per-cycle divider unless
// the smoothing buffer is all zero; drain goes straight to the final state. SUM_W
// is the width of the running sum (11 at defaults).
// Reset clears the histories, phase, zero run and sweep index and loads the register
// defaults. A stalled result sits in the output register; the next request is
// taken meanwhile and its result waits in the final state until the register frees.
module heart_rate_smoother #(
    parameter int RAW_DEPTH    = hrs_pkg::RAW_DEPTH_DEF,
    parameter int STABLE_COUNT = hrs_pkg::STABLE_COUNT_DEF,
    parameter int SMOOTH_DEPTH = hrs_pkg::SMOOTH_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hrs_pkg::S_DATA_W-1:0]    s_tdata,   // [7:0] raw_rate
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hrs_pkg::M_DATA_W-1:0]    m_tdata,   // [7:0] smooth_rate, [9:8] phase
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hrs_pkg::RATE_W-1:0]      cfg_data
);
    import hrs_pkg::*;

    // stability window, cut to the raw history depth
    localparam int WIN    = (STABLE_COUNT < RAW_DEPTH) ? STABLE_COUNT : RAW_DEPTH;
    localparam int MAXD   = (RAW_DEPTH > SMOOTH_DEPTH) ? RAW_DEPTH : SMOOTH_DEPTH;
    localparam int SUM_W  = $clog2(MAXD * 255 + 1);
    localparam int CNT_W  = $clog2(MAXD + 1);
    localparam int SWP_W  = $clog2(MAXD);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // configuration registers
    logic [RATE_W-1:0] near_band_reg, near_band_next;
    logic [RATE_W-1:0] outlier_band_reg, outlier_band_next;
    logic [RATE_W-1:0] min_rate_reg, min_rate_next;
    logic [RATE_W-1:0] zero_run_limit_reg, zero_run_limit_next;

    // control and state
    logic [1:0]         state_reg, state_next;
    logic               mode_reg, mode_next;       // 0 raw sweep, 1 smoothing sweep
    logic [SWP_W-1:0]   swp_reg, swp_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [RATE_W-1:0]  last_output_reg, last_output_next;
    logic [RATE_W-1:0]  zero_run_reg, zero_run_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload
    logic [RATE_W-1:0]   x_reg, x_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    nz_reg, nz_next;
    logic                close_reg, close_next;
    logic [RATE_W-1:0]   result_reg, result_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // datapath wires
    logic              s_fire;
    logic              cfg_fire;
    logic [RATE_W-1:0] x_in;
    logic [RATE_W-1:0] raw_head, smooth_head;
    logic [RATE_W-1:0] head;
    logic [RATE_W-1:0] diff;
    logic [RATE_W-1:0] clamped;
    logic [RATE_W-1:0] t1, t2, t3, t4;
    logic [RATE_W-1:0] zr_inc;
    logic              sweep_last;
    logic              in_win;
    logic [SUM_W-1:0]  acq_sum;
    logic              acq_close;
    logic [SUM_W-1:0]  min_sum;
    logic              div_start;
    logic [SUM_W-1:0]  div_q;
    logic              div_done;
    logic [RATE_W-1:0] mean;
    logic              lock;
    logic              drain_fire;
    cell_ctl_t         raw_ctl, smooth_ctl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign x_in      = s_tdata[RATE_W-1:0];

    // drain phase and the unreachable fourth code both clear everything
    assign drain_fire = s_fire && (phase_reg != PH_ACQUIRE) && (phase_reg != PH_TRACK);

    // soft clamp around the last output; thresholds wrap modulo 256
    assign t1 = last_output_reg + near_band_reg;
    assign t2 = last_output_reg + outlier_band_reg;
    assign t3 = last_output_reg - near_band_reg;
    assign t4 = last_output_reg - outlier_band_reg;

    always_comb begin
        if (x_in > t2) begin
            clamped = t1;
        end else if (x_in < t4) begin
            clamped = t3;
        end else if (x_in > t1 || x_in < t3) begin
            clamped = last_output_reg;
        end else begin
            clamped = x_in;
        end
    end

    // a zero after a nonzero sample restarts the run; cell 0 still holds the previous sample
    assign zr_inc = ((raw_head != '0) ? '0 : zero_run_reg) + 1'b1;

    // sweep reads cell 0 while the row rotates down by one each cycle
    assign head       = mode_reg ? smooth_head : raw_head;
    assign diff       = (head > x_reg) ? (head - x_reg) : (x_reg - head);
    assign sweep_last = mode_reg ? (swp_reg == SWP_W'(SMOOTH_DEPTH - 1))
                                 : (swp_reg == SWP_W'(RAW_DEPTH - 1));

    // acquire window: running sum and closeness including the cell shown now
    assign in_win    = (CNT_W'(swp_reg) < CNT_W'(WIN));
    assign acq_sum   = sum_reg + (in_win ? SUM_W'(head) : SUM_W'(0));
    assign acq_close = close_reg && !(in_win && (diff > near_band_reg));

    // the window mean is below min_rate exactly when the sum is below min_rate * WIN
    assign min_sum = SUM_W'(min_rate_reg) * SUM_W'(WIN);

    assign mean = div_q[RATE_W-1:0];
    assign lock = (state_reg == ST_SWEEP) && !mode_reg && sweep_last
               && (acq_sum >= min_sum) && acq_close;

    always_comb begin
        raw_ctl.clear     = drain_fire;
        raw_ctl.shift     = s_fire && !drain_fire;
        raw_ctl.rotate    = (state_reg == ST_SWEEP) && !mode_reg;
        smooth_ctl.clear  = drain_fire || lock;
        smooth_ctl.shift  = s_fire && (phase_reg == PH_TRACK);
        smooth_ctl.rotate = (state_reg == ST_SWEEP) && mode_reg;
    end

    // configuration writes
    always_comb begin
        near_band_next      = near_band_reg;
        outlier_band_next   = outlier_band_reg;
        min_rate_next       = min_rate_reg;
        zero_run_limit_next = zero_run_limit_reg;
        if (cfg_fire) begin
            case (cfg_index)
                CFG_NEAR_BAND:      near_band_next      = cfg_data;
                CFG_OUTLIER_BAND:   outlier_band_next   = cfg_data;
                CFG_MIN_RATE:       min_rate_next       = cfg_data;
                CFG_ZERO_RUN_LIMIT: zero_run_limit_next = cfg_data;
                default: ;
            endcase
        end
    end

    // main sequencer
    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        swp_next         = swp_reg;
        phase_next       = phase_reg;
        last_output_next = last_output_reg;
        zero_run_next    = zero_run_reg;
        x_next           = x_reg;
        sum_next         = sum_reg;
        nz_next          = nz_reg;
        close_next       = close_reg;
        result_next      = result_reg;
        div_start        = 1'b0;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        // drop the shown result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    x_next     = x_in;
                    swp_next   = '0;
                    sum_next   = '0;
                    nz_next    = '0;
                    close_next = 1'b1;
                    if (phase_reg == PH_ACQUIRE) begin
                        mode_next  = 1'b0;
                        state_next = ST_SWEEP;
                    end else if (phase_reg == PH_TRACK) begin
                        mode_next  = 1'b1;
                        state_next = ST_SWEEP;
                        if (x_in == '0) begin
                            zero_run_next = zr_inc;
                            if (zr_inc >= zero_run_limit_reg) begin
                                phase_next = PH_DRAIN;
                            end
                        end
                    end else begin
                        phase_next       = PH_ACQUIRE;
                        last_output_next = '0;
                        zero_run_next    = '0;
                        result_next      = '0;
                        state_next       = ST_DONE;
                    end
                end
            end
            ST_SWEEP: begin
                swp_next = swp_reg + 1'b1;
                if (!mode_reg) begin
                    sum_next   = acq_sum;
                    close_next = acq_close;
                end else if (head != '0) begin
                    sum_next = sum_reg + SUM_W'(head);
                    nz_next  = nz_reg + 1'b1;
                end
                if (sweep_last) begin
                    if (!mode_reg) begin
                        // window mean below the floor gives zero, else pass the sample
                        if (acq_sum < min_sum) begin
                            result_next = '0;
                        end else begin
                            result_next = x_reg;
                        end
                        if (lock) begin
                            phase_next = PH_TRACK;
                        end
                        last_output_next = result_next;
                        state_next       = ST_DONE;
                    end else if (nz_next == '0) begin
                        // empty smoothing buffer gives zero
                        result_next      = '0;
                        last_output_next = '0;
                        state_next       = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    result_next      = mean;
                    last_output_next = mean;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({phase_reg, result_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_band_reg      <= NEAR_BAND_RST;
            outlier_band_reg   <= OUTLIER_BAND_RST;
            min_rate_reg       <= MIN_RATE_RST;
            zero_run_limit_reg <= ZERO_RUN_LIMIT_RST;
            state_reg          <= ST_IDLE;
            mode_reg           <= 1'b0;
            swp_reg            <= '0;
            phase_reg          <= PH_ACQUIRE;
            last_output_reg    <= '0;
            zero_run_reg       <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            near_band_reg      <= near_band_next;
            outlier_band_reg   <= outlier_band_next;
            min_rate_reg       <= min_rate_next;
            zero_run_limit_reg <= zero_run_limit_next;
            state_reg          <= state_next;
            mode_reg           <= mode_next;
            swp_reg            <= swp_next;
            phase_reg          <= phase_next;
            last_output_reg    <= last_output_next;
            zero_run_reg       <= zero_run_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
        x_reg       <= x_next;
        sum_reg     <= sum_next;
        nz_reg      <= nz_next;
        close_reg   <= close_next;
        result_reg  <= result_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    hrs_chain #(
        .DEPTH (RAW_DEPTH)
    ) u_raw_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (raw_ctl),
        .head_in  (x_in),
        .head_out (raw_head)
    );

    hrs_chain #(
        .DEPTH (SMOOTH_DEPTH)
    ) u_smooth_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (smooth_ctl),
        .head_in  (clamped),
        .head_out (smooth_head)
    );

    // divisor: nonzero count of the smoothing buffer
    hrs_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (nz_next),
        .quotient (div_q),
        .done     (div_done)
    );

`ifndef SYNTHESIS
    a_drain_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_fire |=> (phase_reg == PH_ACQUIRE && last_output_reg == '0
                        && zero_run_reg == '0))
        else $error("drain step left state behind");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished request");

    a_lock_from_acquire: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ACQUIRE && $past(phase_reg) == PH_ACQUIRE) ||
        !(phase_reg == PH_TRACK && $past(phase_reg) == PH_ACQUIRE) ||
        $past(lock))
        else $error("track entered without a stable window");
`endif

endmodule

[hw/rtl/hrs_cell.sv]
// One history cell: a sample register that loads from either neighbor.
module hrs_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hrs_pkg::cell_ctl_t        ctl,
    input  logic [hrs_pkg::RATE_W-1:0] lower_in,
    input  logic [hrs_pkg::RATE_W-1:0] upper_in,
    output logic [hrs_pkg::RATE_W-1:0] value
);
    import hrs_pkg::*;

    logic [RATE_W-1:0] value_reg;
    logic [RATE_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.clear) begin
            value_next = '0;
        end else if (ctl.shift) begin
            value_next = lower_in;
        end else if (ctl.rotate) begin
            value_next = upper_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

[hw/rtl/hrs_chain.sv]
// Row of history cells; cell 0 holds the newest sample and is the read port.
module hrs_chain #(
    parameter int DEPTH = hrs_pkg::RAW_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  hrs_pkg::cell_ctl_t         ctl,
    input  logic [hrs_pkg::RATE_W-1:0] head_in,
    output logic [hrs_pkg::RATE_W-1:0] head_out
);
    import hrs_pkg::*;

    logic [RATE_W-1:0] val [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [RATE_W-1:0] lower;
        logic [RATE_W-1:0] upper;

        if (k == 0) begin : g_first
            assign lower = head_in;
        end else begin : g_mid
            assign lower = val[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign upper = val[0];
        end else begin : g_up
            assign upper = val[k+1];
        end

        hrs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .lower_in (lower),
            .upper_in (upper),
            .value    (val[k])
        );
    end

    assign head_out = val[0];

endmodule

[hw/rtl/hrs_div.sv]
// Restoring divider, one quotient bit per cycle.
module hrs_div #(
    parameter int NUM_W = 11,
    parameter int DEN_W = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);
    localparam int STEP_W = $clog2(NUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  dvs_reg, dvs_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            q_next    = {q_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking stream bench for the heart rate smoother with a built-in rate predictor.
module testbench;
    import hrs_pkg::*;

    localparam int RAW_TAPS       = RAW_DEPTH_DEF;
    localparam int SMOOTH_TAPS    = SMOOTH_DEPTH_DEF;
    // At the default sizes the stability window fits inside the raw history.
    localparam int STABLE_WIN     = (STABLE_COUNT_DEF < RAW_DEPTH_DEF) ?
                                    STABLE_COUNT_DEF : RAW_DEPTH_DEF;
    localparam int RANDOM_SAMPLES = 500;
    localparam int CALM_TAIL      = 80;   // final random samples sent with no idling
    localparam int SETTLE_CYCLES  = 40;   // idle wait after the final settle, before the summary
    localparam int MAX_PRINTED    = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 8'hFC;

    typedef logic [RATE_W-1:0] rate_t;
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        rate_t              rate;
    } smooth_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;     // [7:0] raw_rate
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;            // [7:0] smooth_rate, [9:8] phase
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    rate_t                  cfg_data  = '0;

    // Predictor copy of the registers and of the block state
    rate_t             near_band, outlier_band, floor_rate, zero_limit;
    rate_t             raw_taps [RAW_TAPS];
    rate_t             smooth_taps [SMOOTH_TAPS];
    rate_t             held_rate;
    rate_t             zero_streak;
    logic [PHASE_W-1:0] lock_phase;

    smooth_result_t expected_rates [$];
    smooth_result_t due;
    bit             quiet = 1'b0;     // no idling on either side while set
    int             samples_sent = 0;
    int             results_seen = 0;
    int             mismatches = 0;
    int             settings_used = 0;
    int             stall_left = 0;

    heart_rate_smoother u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_track_state();
        raw_taps    = '{default: '0};
        smooth_taps = '{default: '0};
        held_rate   = '0;
        zero_streak = '0;
        lock_phase  = PH_ACQUIRE;
    endfunction

    function automatic void reset_model();
        near_band    = NEAR_BAND_RST;
        outlier_band = OUTLIER_BAND_RST;
        floor_rate   = MIN_RATE_RST;
        zero_limit   = ZERO_RUN_LIMIT_RST;
        clear_track_state();
    endfunction

    function automatic smooth_result_t predict_smooth(input rate_t rate_in);
        smooth_result_t res;
        rate_t          prev_rate, up_near, up_far, down_near, down_far, clamped;
        int             sum, hits, dev;
        for (int k = RAW_TAPS - 1; k > 0; k--) raw_taps[k] = raw_taps[k - 1];
        raw_taps[0] = rate_in;
        prev_rate   = raw_taps[1];
        res.rate    = '0;
        case (lock_phase)
            PH_ACQUIRE: begin
                sum  = 0;
                hits = 0;
                for (int k = 0; k < STABLE_WIN; k++) begin
                    sum += raw_taps[k];
                    dev = (raw_taps[k] > rate_in) ? raw_taps[k] - rate_in
                                                  : rate_in - raw_taps[k];
                    if (dev <= near_band) hits++;
                end
                if (rate_t'(sum / STABLE_WIN) >= floor_rate) begin
                    res.rate = rate_in;
                    // lock once the whole window sits close to the new sample
                    if (hits >= STABLE_WIN) begin
                        lock_phase  = PH_TRACK;
                        smooth_taps = '{default: '0};
                    end
                end
                held_rate = res.rate;
            end
            PH_TRACK: begin
                if (rate_in == '0) begin
                    // a zero after a nonzero sample restarts the run; nonzero keeps it
                    if (prev_rate != '0) zero_streak = '0;
                    zero_streak = zero_streak + 8'd1;
                    if (zero_streak >= zero_limit) lock_phase = PH_DRAIN;
                end
                // band edges wrap at 8 bits
                up_near   = held_rate + near_band;
                up_far    = held_rate + outlier_band;
                down_near = held_rate - near_band;
                down_far  = held_rate - outlier_band;
                clamped   = rate_in;
                if (rate_in > up_far)
                    clamped = up_near;
                else if (rate_in < down_far)
                    clamped = down_near;
                else if (rate_in > up_near || rate_in < down_near)
                    clamped = held_rate;
                for (int k = SMOOTH_TAPS - 1; k > 0; k--) smooth_taps[k] = smooth_taps[k - 1];
                smooth_taps[0] = clamped;
                sum  = 0;
                hits = 0;
                for (int k = 0; k < SMOOTH_TAPS; k++) begin
                    if (smooth_taps[k] != '0) begin
                        sum += smooth_taps[k];
                        hits++;
                    end
                end
                if (hits != 0) res.rate = rate_t'(sum / hits);
                held_rate = res.rate;
            end
            default: begin
                // drain, and the unused code: wipe everything, this sample too
                clear_track_state();
            end
        endcase
        res.phase = lock_phase;
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch on result %0d, %s: got %0d, want %0d",
                     $time, results_seen, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_rates.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata, 0);
            end else begin
                due = expected_rates.pop_front();
                if (m_tdata[RATE_W-1:0] !== due.rate)
                    report_mismatch("smooth_rate", m_tdata[RATE_W-1:0], due.rate);
                if (m_tdata[RATE_W+PHASE_W-1:RATE_W] !== due.phase)
                    report_mismatch("phase", m_tdata[RATE_W+PHASE_W-1:RATE_W], due.phase);
                if (m_tdata[M_DATA_W-1:RATE_W+PHASE_W] !== '0)
                    report_mismatch("padding", m_tdata[M_DATA_W-1:RATE_W+PHASE_W], 0);
            end
        end
    end

    // Result side back-pressure: random stall bursts, none while quiet
    always @(posedge aclk) begin
        if (quiet || !aresetn) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- drivers

    // Leave tvalid high after the request so a following one can go back to back.
    task automatic send_rate(input rate_t rate_in);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rate_in;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_rates.push_back(predict_smooth(rate_in));
        samples_sent++;
    endtask

    // Drop tvalid and hold until every pending result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input rate_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            CFG_NEAR_BAND:      near_band    = value;
            CFG_OUTLIER_BAND:   outlier_band = value;
            CFG_MIN_RATE:       floor_rate   = value;
            CFG_ZERO_RUN_LIMIT: zero_limit   = value;
            default: ;
        endcase
    endtask

    task automatic load_registers(input rate_t near, input rate_t outlier,
                                  input rate_t floor_val, input rate_t limit,
                                  input bit poke_unmapped);
        settle();
        write_reg(CFG_NEAR_BAND, near);
        write_reg(CFG_OUTLIER_BAND, outlier);
        write_reg(CFG_MIN_RATE, floor_val);
        write_reg(CFG_ZERO_RUN_LIMIT, limit);
        if (poke_unmapped) write_reg(CFG_UNMAPPED, rate_t'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ---------------------------------------------------------------- sequences

    function automatic rate_t clip_rate(input int v);
        if (v < 0) return '0;
        if (v > 255) return 8'd255;
        return rate_t'(v);
    endfunction

    task automatic send_near(input int center, input int spread);
        send_rate(clip_rate(center + $urandom_range(0, 2 * spread) - spread));
    endtask

    // Tight cluster: every pair stays within the near band, so acquire can lock.
    task automatic feed_lock(input int center, input int count);
        int spread;
        spread = ((near_band < 8) ? near_band : 8) / 2;
        repeat (count) send_near(center, spread);
    endtask

    task automatic feed_tracking(input int center, input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 19);
            if (pick < 11)
                send_near(center, near_band);
            else if (pick < 14)
                send_near(center, outlier_band + 4);
            else if (pick < 16)
                send_rate(rate_t'($urandom_range(0, 255)));
            else
                send_rate('0);
        end
    endtask

    task automatic feed_episode();
        int kind, center;
        kind   = $urandom_range(0, 9);
        center = $urandom_range(floor_rate, 255);
        if (kind < 7) begin
            // lock, track, a zero run to drain if zero_limit <= 12, then the drain step
            feed_lock(center, $urandom_range(4, 6));
            feed_tracking(center, $urandom_range(4, 20));
            if (zero_limit <= 12) begin
                repeat ((zero_limit == 0) ? 1 : zero_limit) send_rate('0);
                send_rate(rate_t'($urandom_range(0, 255)));
            end
        end else if (kind < 9) begin
            repeat ($urandom_range(3, 10)) send_rate(rate_t'($urandom_range(0, 255)));
        end else begin
            // broken lock: a short cluster spoiled by a stray sample and zeros
            feed_lock(center, $urandom_range(1, 3));
            send_near(center, outlier_band + 20);
            repeat ($urandom_range(1, 4)) send_rate('0);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Register reset values: field extremes, lock at the top of the range so the
    // band edges wrap, zero run restart and drain, drain step, relock and clamps.
    task automatic test_power_on_defaults();
        rate_t script [] = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                             8'd100, 8'd0, 8'd7, 8'd0, 8'd0, 8'd0, 8'd77,
                             8'd80, 8'd82, 8'd78, 8'd81, 8'd95, 8'd120, 8'd30};
        foreach (script[i]) send_rate(script[i]);
    endtask

    // Zero bands and zero floor: a zero run limit of zero that drains on the first
    // zero, the drain step, lock on a run of equal samples, and hard clamping.
    task automatic test_degenerate_bands();
        rate_t script [] = '{8'd0, 8'd0, 8'd9, 8'd5, 8'd5, 8'd5, 8'd5,
                             8'd200, 8'd1};
        load_registers(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        foreach (script[i]) send_rate(script[i]);
    endtask

    task automatic test_random_sessions();
        int first, episodes, round;
        first    = samples_sent;
        episodes = 0;
        while (samples_sent - first < RANDOM_SAMPLES) begin
            quiet = (samples_sent - first >= RANDOM_SAMPLES - CALM_TAIL) ||
                    (episodes % 7 == 3);
            if (episodes % 5 == 0) begin
                round = episodes / 5;
                case (round)
                    0: load_registers(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
                    1: load_registers(8'd0, 8'd0, 8'd0, 8'd1, 1'b0);
                    2: load_registers(8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
                    default: begin
                        load_registers(($urandom_range(0, 7) == 0) ?
                                           rate_t'($urandom_range(0, 255)) :
                                           rate_t'($urandom_range(0, 20)),
                                       rate_t'($urandom_range(0, 40)),
                                       rate_t'($urandom_range(0, 120)),
                                       rate_t'($urandom_range(1, 6)), 1'b0);
                    end
                endcase
            end
            feed_episode();
            episodes++;
        end
    endtask

    // ---------------------------------------------------------------- run

    initial begin
        reset_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_power_on_defaults();
        test_degenerate_bands();
        test_random_sessions();
        quiet = 1'b1;
        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d raw samples and checked %0d smoothed results", samples_sent,
                 results_seen);
        $display("Covered %0d register settings, %0d mismatches", settings_used, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Watchdog expired with %0d results outstanding", expected_rates.size());
        $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/hrs_pkg.sv
hw/rtl/hrs_cell.sv
hw/rtl/hrs_chain.sv
hw/rtl/hrs_div.sv
hw/rtl/heart_rate_smoother.sv
bench/testbench.sv
